>>> rtl/core/nnru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnru_pkg: shared types and constants
// Codes, field widths and default sizes for the row upscaler.
// ----------------------------------------------------------------------------
package nnru_pkg;

  // default sizes
  localparam int ROW_ELEMS_DEF = 4096;
  localparam int MAX_SCALE_DEF = 16;

  // field widths
  localparam int DATA_W  = 32;
  localparam int CFG_IW  = 4;
  localparam int CFG_DW  = 13;
  localparam int SCALE_W = 5;
  localparam int WIDTH_W = 13;
  localparam int CHAN_W  = 13;
  localparam int LEN_W   = WIDTH_W + CHAN_W;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_SCALE  = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_CHANS  = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_LAYOUT = 4'd3;

  // item kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_EMIT   = 2'd1,
    ST_DROP   = 2'd2,
    ST_NRDY   = 2'd3
  } status_t;

  // per-item result info traveling beside the buffer read
  typedef struct packed {
    status_t status;
    logic    last;
  } meta_t;

endpackage

>>> rtl/core/nearest_neighbor_row_upscaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_row_upscaler_unit: integer-factor row upscaler
// Loads one tensor row into a line buffer and streams the enlarged block.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one item per handshake; in_tuser is the kind (0 load, 1 pull) and
//    in_tdata the 32-bit element pattern used by a load.
//  - out_*: one result item per input item, in order; out_tuser is the status
//    (0 loaded, 1 emitted, 2 dropped, 3 not ready), out_tdata the element on
//    an emit (else 0), out_tlast marks the final element of the block.
//  - cfg_*: register writes (0 scale, 1 row width, 2 channels, 3 layout); a
//    valid write to one of these empties the row. cfg_ready is always high.
//  - Accept to out_tvalid: one line buffer read stage and one queue register.
//    One item per cycle is sustained while the output queue has room, as
//    each item makes at most one buffer access (a load write, a pull read).
//  - Reset restores the register defaults (scale 2, width 1, channels 1,
//    planar) and empties the row; buffer contents are left as they are, and
//    no clearing pass runs.
//  - When the receiver stalls, up to three results wait in the output queue,
//    then in_tready drops until one is taken.
// ----------------------------------------------------------------------------
module nearest_neighbor_row_upscaler_unit #(
  parameter int ROW_ELEMS = nnru_pkg::ROW_ELEMS_DEF,
  parameter int MAX_SCALE = nnru_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] value
  input  logic                           in_tuser,   // [0] op
  // result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] data
  output logic [1:0]                     out_tuser,  // [1:0] status
  output logic                           out_tlast,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nnru_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [nnru_pkg::CFG_DW-1:0]    cfg_data
);
  import nnru_pkg::*;

  localparam int AW = $clog2(ROW_ELEMS);
  localparam int CW = $clog2(ROW_ELEMS + 1);
  localparam int SW = $clog2(MAX_SCALE);

  logic              in_fire;
  logic              cfg_clr;
  logic [SW-1:0]     s_m1;
  logic [AW-1:0]     w_m1, g_m1;
  logic [CW-1:0]     lim;
  logic              row_ok;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic              s1_vld;
  meta_t             s1_meta;
  logic              slot_free;
  status_t           out_status;

  assign cfg_ready = 1'b1;
  assign in_tready = slot_free;
  assign in_fire   = in_tvalid && in_tready;

  nnru_cfg #(
    .ROW_ELEMS (ROW_ELEMS),
    .MAX_SCALE (MAX_SCALE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_clr   (cfg_clr),
    .s_m1      (s_m1),
    .w_m1      (w_m1),
    .g_m1      (g_m1),
    .lim       (lim),
    .row_ok    (row_ok)
  );

  nnru_seq #(
    .ROW_ELEMS (ROW_ELEMS),
    .MAX_SCALE (MAX_SCALE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .cfg_clr   (cfg_clr),
    .s_m1      (s_m1),
    .w_m1      (w_m1),
    .g_m1      (g_m1),
    .lim       (lim),
    .row_ok    (row_ok),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .s1_vld    (s1_vld),
    .s1_meta   (s1_meta)
  );

  nnru_lbuf #(
    .ROW_ELEMS (ROW_ELEMS)
  ) u_lbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nnru_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_vld),
    .push_meta  (s1_meta),
    .push_data  (mem_rdata),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_status;

`ifndef SYNTHESIS
  // every accepted item reaches the queue in the cycle after its accept
  a_item_to_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld)
    else $error("accepted item lost before queue");

  // a buffer write and a buffer read never share a cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("two buffer accesses in one cycle");

  // a flagged final element is always an emitted one
  a_last_is_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_status == ST_EMIT))
    else $error("last flag on a non-emit result");
`endif

endmodule

>>> rtl/core/nnru_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnru_cfg: configuration registers
// Holds the raw registers and the effective values derived from them.
// ----------------------------------------------------------------------------
module nnru_cfg #(
  parameter int ROW_ELEMS = nnru_pkg::ROW_ELEMS_DEF,
  parameter int MAX_SCALE = nnru_pkg::MAX_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [nnru_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [nnru_pkg::CFG_DW-1:0]      cfg_data,
  output logic                             cfg_clr,
  output logic [$clog2(MAX_SCALE)-1:0]     s_m1,
  output logic [$clog2(ROW_ELEMS)-1:0]     w_m1,
  output logic [$clog2(ROW_ELEMS)-1:0]     g_m1,
  output logic [$clog2(ROW_ELEMS+1)-1:0]   lim,
  output logic                             row_ok
);
  import nnru_pkg::*;

  localparam int AW = $clog2(ROW_ELEMS);
  localparam int CW = $clog2(ROW_ELEMS + 1);
  localparam int SW = $clog2(MAX_SCALE);
  localparam int XW = (AW > WIDTH_W) ? AW : WIDTH_W;

  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [WIDTH_W-1:0] width_r, width_nxt;
  logic [CHAN_W-1:0]  chans_r, chans_nxt;
  logic               layout_r, layout_nxt;

  logic [SW-1:0]      s_m1_r, s_m1_nxt;
  logic [AW-1:0]      w_m1_r, w_m1_nxt;
  logic [AW-1:0]      g_m1_r, g_m1_nxt;
  logic [CW-1:0]      lim_r, lim_nxt;
  logic               row_ok_r, row_ok_nxt;

  logic [7:0]         s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [CHAN_W-1:0]  g_eff;
  logic [XW-1:0]      w_ext;
  logic [XW-1:0]      g_ext;
  logic [LEN_W-1:0]   len;

  // register write decode
  always_comb begin
    scale_nxt  = scale_r;
    width_nxt  = width_r;
    chans_nxt  = chans_r;
    layout_nxt = layout_r;
    cfg_clr    = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SCALE: begin
          scale_nxt = cfg_data[SCALE_W-1:0];
          cfg_clr   = 1'b1;
        end
        CFG_WIDTH: begin
          width_nxt = cfg_data[WIDTH_W-1:0];
          cfg_clr   = 1'b1;
        end
        CFG_CHANS: begin
          chans_nxt = cfg_data[CHAN_W-1:0];
          cfg_clr   = 1'b1;
        end
        CFG_LAYOUT: begin
          layout_nxt = cfg_data[0];
          cfg_clr    = 1'b1;
        end
        default: cfg_clr = 1'b0;
      endcase
    end
  end

  // effective values: zero reads as one, scale clamps at the maximum
  always_comb begin
    if (scale_nxt == '0)
      s_eff = 8'd1;
    else if ({3'b000, scale_nxt} > 8'(MAX_SCALE))
      s_eff = 8'(MAX_SCALE);
    else
      s_eff = {3'b000, scale_nxt};

    w_eff = (width_nxt == '0) ? WIDTH_W'(1) : width_nxt;
    if (!layout_nxt)
      g_eff = CHAN_W'(1);
    else
      g_eff = (chans_nxt == '0) ? CHAN_W'(1) : chans_nxt;

    s_m1_nxt = SW'(s_eff - 8'd1);
    w_ext    = XW'(w_eff) - XW'(1);
    g_ext    = XW'(g_eff) - XW'(1);
    w_m1_nxt = w_ext[AW-1:0];
    g_m1_nxt = g_ext[AW-1:0];

    // row length and its fill limit inside the buffer
    len        = LEN_W'(w_eff) * LEN_W'(g_eff);
    row_ok_nxt = (len <= LEN_W'(ROW_ELEMS));
    lim_nxt    = row_ok_nxt ? len[CW-1:0] : CW'(ROW_ELEMS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(2);
      width_r  <= WIDTH_W'(1);
      chans_r  <= CHAN_W'(1);
      layout_r <= 1'b0;
      s_m1_r   <= SW'(1);
      w_m1_r   <= '0;
      g_m1_r   <= '0;
      lim_r    <= CW'(1);
      row_ok_r <= 1'b1;
    end else if (cfg_clr) begin
      scale_r  <= scale_nxt;
      width_r  <= width_nxt;
      chans_r  <= chans_nxt;
      layout_r <= layout_nxt;
      s_m1_r   <= s_m1_nxt;
      w_m1_r   <= w_m1_nxt;
      g_m1_r   <= g_m1_nxt;
      lim_r    <= lim_nxt;
      row_ok_r <= row_ok_nxt;
    end
  end

  assign s_m1   = s_m1_r;
  assign w_m1   = w_m1_r;
  assign g_m1   = g_m1_r;
  assign lim    = lim_r;
  assign row_ok = row_ok_r;

`ifndef SYNTHESIS
  // the limit never exceeds the buffer
  a_lim_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r <= CW'(ROW_ELEMS))
    else $error("fill limit beyond buffer size");

  // the fill limit is never zero
  a_lim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r != '0)
    else $error("zero fill limit");

  // a known register write is taken next cycle; the same write empties the row
  a_clr_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clr |=> (scale_r == $past(scale_nxt)) && (layout_r == $past(layout_nxt)))
    else $error("register write not taken");
`endif

endmodule

>>> rtl/core/nnru_lbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnru_lbuf: line buffer
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nnru_lbuf #(
  parameter int ROW_ELEMS = nnru_pkg::ROW_ELEMS_DEF
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(ROW_ELEMS)-1:0]       waddr,
  input  logic [nnru_pkg::DATA_W-1:0]        wdata,
  input  logic                               re,
  input  logic [$clog2(ROW_ELEMS)-1:0]       raddr,
  output logic [nnru_pkg::DATA_W-1:0]        rdata
);
  import nnru_pkg::*;

  logic [DATA_W-1:0] mem [ROW_ELEMS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/nnru_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnru_seq: load and pull sequencer
// Tracks the fill level and walks the enlarged block, driving the buffer ports.
// ----------------------------------------------------------------------------
module nnru_seq #(
  parameter int ROW_ELEMS = nnru_pkg::ROW_ELEMS_DEF,
  parameter int MAX_SCALE = nnru_pkg::MAX_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_fire,
  input  logic                             in_op,
  input  logic [nnru_pkg::DATA_W-1:0]      in_value,
  input  logic                             cfg_clr,
  input  logic [$clog2(MAX_SCALE)-1:0]     s_m1,
  input  logic [$clog2(ROW_ELEMS)-1:0]     w_m1,
  input  logic [$clog2(ROW_ELEMS)-1:0]     g_m1,
  input  logic [$clog2(ROW_ELEMS+1)-1:0]   lim,
  input  logic                             row_ok,
  output logic                             mem_we,
  output logic [$clog2(ROW_ELEMS)-1:0]     mem_waddr,
  output logic [nnru_pkg::DATA_W-1:0]      mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(ROW_ELEMS)-1:0]     mem_raddr,
  output logic                             s1_vld,
  output nnru_pkg::meta_t                  s1_meta
);
  import nnru_pkg::*;

  localparam int AW = $clog2(ROW_ELEMS);
  localparam int CW = $clog2(ROW_ELEMS + 1);
  localparam int SW = $clog2(MAX_SCALE);

  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] chan_r, chan_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [SW-1:0] copy_r, copy_nxt;
  logic [SW-1:0] rep_r, rep_nxt;
  logic          s1_vld_r;
  meta_t         s1_meta_r, meta_nxt;

  logic is_load, is_pull, room, row_full, emit;
  logic chan_end, copy_end, col_end, rep_end, blk_end;

  assign is_load  = in_fire && (in_op == OP_LOAD);
  assign is_pull  = in_fire && (in_op == OP_PULL);
  assign room     = (fill_r < lim);
  assign row_full = row_ok && (fill_r == lim);
  assign emit     = is_pull && row_full;

  assign chan_end = (chan_r == g_m1);
  assign copy_end = (copy_r == s_m1);
  assign col_end  = (col_r == w_m1);
  assign rep_end  = (rep_r == s_m1);
  assign blk_end  = chan_end && copy_end && col_end && rep_end;

  // buffer ports: loads write at the fill point, pulls read base + channel
  assign mem_we    = is_load && room;
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_wdata = in_value;
  assign mem_re    = emit;
  assign mem_raddr = base_r + chan_r;

  // counter walk: channel, copy, column, row repeat
  always_comb begin
    fill_nxt = fill_r;
    chan_nxt = chan_r;
    copy_nxt = copy_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    rep_nxt  = rep_r;

    if (mem_we) begin
      fill_nxt = fill_r + CW'(1);
    end

    if (emit) begin
      if (!chan_end) begin
        chan_nxt = chan_r + AW'(1);
      end else begin
        chan_nxt = '0;
        if (!copy_end) begin
          copy_nxt = copy_r + SW'(1);
        end else begin
          copy_nxt = '0;
          if (!col_end) begin
            col_nxt  = col_r + AW'(1);
            base_nxt = base_r + g_m1 + AW'(1);
          end else begin
            col_nxt  = '0;
            base_nxt = '0;
            if (!rep_end) begin
              rep_nxt = rep_r + SW'(1);
            end else begin
              rep_nxt  = '0;
              fill_nxt = '0;
            end
          end
        end
      end
    end

    // a register write empties the row
    if (cfg_clr) begin
      fill_nxt = '0;
      chan_nxt = '0;
      copy_nxt = '0;
      col_nxt  = '0;
      base_nxt = '0;
      rep_nxt  = '0;
    end
  end

  // result info for the item in flight
  always_comb begin
    meta_nxt.last = emit && blk_end;
    if (in_op == OP_LOAD)
      meta_nxt.status = room ? ST_LOADED : ST_DROP;
    else
      meta_nxt.status = row_full ? ST_EMIT : ST_NRDY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      chan_r   <= '0;
      copy_r   <= '0;
      col_r    <= '0;
      base_r   <= '0;
      rep_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      chan_r   <= chan_nxt;
      copy_r   <= copy_nxt;
      col_r    <= col_nxt;
      base_r   <= base_nxt;
      rep_r    <= rep_nxt;
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meta_r <= meta_nxt;
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_meta = s1_meta_r;

`ifndef SYNTHESIS
  // walk counters stay inside the block while the row is complete
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    row_full |-> (chan_r <= g_m1) && (copy_r <= s_m1) && (col_r <= w_m1) && (rep_r <= s_m1))
    else $error("walk counter out of range");

  // the final element empties the row
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && blk_end) |=> (fill_r == '0) && (base_r == '0))
    else $error("row not emptied after final element");

  // the base address only moves at a column step or wraps to zero
  a_base_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!emit && !cfg_clr) |=> $stable(base_r))
    else $error("base address moved without a pull");
`endif

endmodule

>>> rtl/core/nnru_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnru_obuf: result queue
// Three-entry queue between the buffer read stage and the result channel.
// ----------------------------------------------------------------------------
module nnru_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  nnru_pkg::meta_t               push_meta,
  input  logic [nnru_pkg::DATA_W-1:0]   push_data,
  output logic                          slot_free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output nnru_pkg::status_t             out_status,
  output logic [nnru_pkg::DATA_W-1:0]   out_data,
  output logic                          out_last
);
  import nnru_pkg::*;

  localparam int DEPTH = 3;

  typedef struct packed {
    meta_t             meta;
    logic [DATA_W-1:0] data;
  } entry_t;

  entry_t     q_r [DEPTH];
  entry_t     wr_ent;
  logic [1:0] wr_ptr_r, rd_ptr_r, cnt_r;
  logic       pop;
  logic [2:0] used;

  assign pop = out_tvalid && out_tready;

  // data is zero for everything but an emitted element
  always_comb begin
    wr_ent.meta = push_meta;
    wr_ent.data = (push_meta.status == ST_EMIT) ? push_data : '0;
  end

  // room for one more item counting the read stage
  assign used      = {1'b0, cnt_r} + {2'b00, push};
  assign slot_free = (used < 3'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_status = q_r[rd_ptr_r].meta.status;
  assign out_last   = q_r[rd_ptr_r].meta.last;
  assign out_data   = q_r[rd_ptr_r].data;

`ifndef SYNTHESIS
  // the read stage never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'(DEPTH)))
    else $error("result queue overflow");

  // occupancy tracks the pointers
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == 2'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  // an item pushed into an empty queue is shown once it is registered
  a_push_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cnt_r == '0) |=> out_tvalid && (out_status == $past(push_meta.status)))
    else $error("pushed item not presented");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for nearest_neighbor_row_upscaler_unit
// Loads rows through the input stream and pulls the enlarged blocks back.
// Each accepted item is run through a local model of the line buffer and its
// counters, and each result item is compared with the oldest prediction.
// Directed tests cover the defaults, register limits, full and overflowing
// rows and back-pressure. A random phase follows, with random row shapes,
// settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import nnru_pkg::*;

  localparam int LINE_DEPTH     = ROW_ELEMS_DEF;
  localparam int SCALE_MAX      = MAX_SCALE_DEF;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  localparam logic LAYOUT_PLANAR      = 1'b0;
  localparam logic LAYOUT_INTERLEAVED = 1'b1;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;
  typedef enum int {
    ROW_CLEAN, ROW_EARLY_PULL, ROW_EXTRA_LOAD, ROW_LOAD_MIDWAY, ROW_CUT_SHORT,
    ROW_EXTRA_PULL
  } row_shape_e;

  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } nn_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [31:0]         out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  nearest_neighbor_row_upscaler_unit #(
    .ROW_ELEMS (LINE_DEPTH),
    .MAX_SCALE (SCALE_MAX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model of the row buffer, its counters and the register file
  // ---------------------------------------------------------------------------
  logic [31:0]  row_mem [0:LINE_DEPTH-1];
  int unsigned  fill_n   = 0;
  int unsigned  chan_i   = 0;
  int unsigned  copy_i   = 0;
  int unsigned  col_i    = 0;
  int unsigned  rep_i    = 0;
  logic [4:0]   scale_r  = 5'd2;
  logic [12:0]  width_r  = 13'd1;
  logic [12:0]  chans_r  = 13'd1;
  logic         layout_r = LAYOUT_PLANAR;

  nn_result_t   pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  idle_cycles = 0;

  // sender and receiver behavior knobs
  bit           tx_idle = 1'b0;
  int unsigned  burst_left = 0;
  rx_mode_e     rx_mode = RX_ALWAYS;
  int unsigned  hold_req = 0;

  function automatic int unsigned eff_scale();
    if (scale_r == 0) return 1;
    if (scale_r > SCALE_MAX) return SCALE_MAX;
    return scale_r;
  endfunction

  function automatic int unsigned eff_width();
    return (width_r == 0) ? 1 : width_r;
  endfunction

  // channels only group elements in interleaved layout
  function automatic int unsigned eff_group();
    if (layout_r == LAYOUT_PLANAR) return 1;
    return (chans_r == 0) ? 1 : chans_r;
  endfunction

  function automatic void clear_row_state();
    fill_n = 0;
    chan_i = 0;
    copy_i = 0;
    col_i  = 0;
    rep_i  = 0;
  endfunction

  // register write; unknown indexes leave everything alone
  function automatic void apply_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      CFG_SCALE:  scale_r  = val[4:0];
      CFG_WIDTH:  width_r  = val;
      CFG_CHANS:  chans_r  = val;
      CFG_LAYOUT: layout_r = val[0];
      default:    return;
    endcase
    clear_row_state();
  endfunction

  // one load or pull through the row model
  function automatic nn_result_t upscale_step(logic op, logic [31:0] value);
    nn_result_t  r;
    int unsigned s, w, g, len;
    s = eff_scale();
    w = eff_width();
    g = eff_group();
    len = w * g;
    r.status = ST_LOADED;
    r.data   = '0;
    r.last   = 1'b0;
    if (op == OP_LOAD) begin
      if (fill_n >= len || fill_n >= LINE_DEPTH) begin
        r.status = ST_DROP;
      end else begin
        row_mem[fill_n] = value;
        fill_n++;
      end
      return r;
    end
    if (len > LINE_DEPTH || fill_n != len) begin
      r.status = ST_NRDY;
      return r;
    end
    r.status = ST_EMIT;
    r.data   = row_mem[col_i * g + chan_i];
    // channel, then copy, then column, then output row
    chan_i++;
    if (chan_i >= g) begin
      chan_i = 0;
      copy_i++;
      if (copy_i >= s) begin
        copy_i = 0;
        col_i++;
        if (col_i >= w) begin
          col_i = 0;
          rep_i++;
          if (rep_i >= s) begin
            r.last = 1'b1;
            clear_row_state();
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      // further mismatches are counted only
      if (mismatches <= MAX_REPORTS)
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks results, tracks register writes, predicts accepted items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nn_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("result item with nothing expected: status %0d data %0h",
                   out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("data", want.data, out_tdata);
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        pending_results.push_back(upscale_step(in_tuser, in_tdata));

      // watchdog on cycles without any handshake
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern per mode, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int unsigned phase;
    int unsigned n;
    out_tready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if (hold_req != 0) begin
        n = hold_req;
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_tready <= 1'b1;
          RX_RANDOM:   out_tready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_tready <= ((phase % 7) < 4);
          default:     out_tready <= ($urandom_range(0, 15) > 11);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one item on the input stream; valid stays high within a burst
  task automatic send_item(logic op, logic [31:0] value);
    int unsigned gap;
    @(negedge clk);
    if (tx_idle && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DW-1:0] sc, logic [CFG_DW-1:0] wd,
                          logic [CFG_DW-1:0] ch, logic lay);
    wait_idle();
    write_reg(CFG_SCALE, sc);
    write_reg(CFG_WIDTH, wd);
    write_reg(CFG_CHANS, ch);
    write_reg(CFG_LAYOUT, {12'd0, lay});
  endtask

  // loads one row and pulls its block, with an optional irregularity
  task automatic play_row(row_shape_e shape);
    int unsigned len, n_out, cut;
    len   = eff_width() * eff_group();
    n_out = eff_scale() * eff_scale() * len;
    cut   = $urandom_range(0, n_out - 1);
    if (shape == ROW_EARLY_PULL)
      repeat ($urandom_range(1, 2)) send_item(OP_PULL, rand_word());
    repeat (len) send_item(OP_LOAD, rand_word());
    if (shape == ROW_EXTRA_LOAD) send_item(OP_LOAD, rand_word());
    for (int unsigned k = 0; k < n_out; k++) begin
      if (shape == ROW_CUT_SHORT && k == cut) break;
      if (shape == ROW_LOAD_MIDWAY && k == cut) send_item(OP_LOAD, rand_word());
      send_item(OP_PULL, rand_word());
    end
    if (shape == ROW_EXTRA_PULL) send_item(OP_PULL, rand_word());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: scale 2, one pixel, planar
  task automatic test_defaults_after_reset();
    tx_idle = 1'b0;
    rx_mode = RX_ALWAYS;
    send_item(OP_PULL, 32'h0000_0000);     // row empty
    send_item(OP_LOAD, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 32'h0000_0000);     // row already full
    repeat (3) send_item(OP_PULL, 32'hFFFF_FFFF);
    send_item(OP_LOAD, 32'h1234_5678);     // dropped while pulling
    send_item(OP_PULL, 32'h0000_0000);     // last of block
    send_item(OP_PULL, 32'h0000_0000);     // row emptied again
    send_item(OP_LOAD, 32'h0000_0000);
    repeat (4) send_item(OP_PULL, 32'hFFFF_FFFF);
  endtask

  // scale of zero, above the maximum, and junk above the field
  task automatic test_scale_limits();
    tx_idle = 1'b1;
    rx_mode = RX_RANDOM;
    set_regs(13'd0, 13'd3, 13'd1, LAYOUT_PLANAR);
    play_row(ROW_CLEAN);
    set_regs(13'd31, 13'd1, 13'd1, LAYOUT_PLANAR);
    play_row(ROW_CLEAN);
    set_regs(13'h1FE3, 13'd2, 13'd1, LAYOUT_PLANAR);
    play_row(ROW_CLEAN);
  endtask

  // zero width and channel counts count as one
  task automatic test_zero_sizes();
    tx_idle = 1'b1;
    rx_mode = RX_PERIODIC;
    set_regs(13'd2, 13'd0, 13'd0, LAYOUT_INTERLEAVED);
    play_row(ROW_CLEAN);
    set_regs(13'd2, 13'd0, 13'd5, LAYOUT_PLANAR);
    play_row(ROW_CLEAN);
    set_regs(13'd2, 13'd2, 13'd3, LAYOUT_INTERLEAVED);
    play_row(ROW_EXTRA_PULL);
  endtask

  // unknown indexes keep a partial row, known ones empty it
  task automatic test_register_writes();
    tx_idle = 1'b0;
    rx_mode = RX_ALWAYS;
    set_regs(13'd2, 13'd3, 13'd1, LAYOUT_PLANAR);
    repeat (2) send_item(OP_LOAD, rand_word());
    wait_idle();
    for (int k = 4; k < 16; k++) write_reg(CFG_IW'(k), 13'($urandom));
    send_item(OP_LOAD, rand_word());
    repeat (12) send_item(OP_PULL, rand_word());
    repeat (2) send_item(OP_LOAD, rand_word());
    wait_idle();
    write_reg(CFG_WIDTH, 13'd3);
    send_item(OP_PULL, rand_word());       // nothing loaded any more
    play_row(ROW_CLEAN);
    repeat (3) send_item(OP_LOAD, rand_word());
    wait_idle();
    write_reg(CFG_CHANS, 13'd7);
    play_row(ROW_CLEAN);
  endtask

  // long rows at scale one, both layouts
  task automatic test_full_rows();
    tx_idle = 1'b1;
    rx_mode = RX_RANDOM;
    set_regs(13'd1, 13'd64, 13'd1, LAYOUT_PLANAR);
    play_row(ROW_EXTRA_LOAD);
    rx_mode = RX_PERIODIC;
    set_regs(13'd1, 13'd1, 13'd64, LAYOUT_INTERLEAVED);
    play_row(ROW_LOAD_MIDWAY);
  endtask

  // a row longer than the buffer never completes
  task automatic test_row_overflow();
    tx_idle = 1'b0;
    rx_mode = RX_ALWAYS;
    set_regs(13'd2, 13'd8191, 13'd1, LAYOUT_PLANAR);
    repeat (18) send_item(OP_LOAD, rand_word());
    repeat (2) send_item(OP_PULL, rand_word());
    set_regs(13'd1, 13'd8191, 13'd8191, LAYOUT_INTERLEAVED);
    repeat (2) send_item(OP_LOAD, rand_word());
    send_item(OP_PULL, rand_word());
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    set_regs(13'd2, 13'd4, 13'd1, LAYOUT_PLANAR);
    tx_idle = 1'b0;
    rx_mode = RX_ALWAYS;
    hold_req = 80;
    play_row(ROW_CLEAN);
    wait_idle();
    tx_idle = 1'b1;
    rx_mode = RX_SPARSE;
    repeat (2) play_row(ROW_CLEAN);
  endtask

  // random settings, row shapes and flow control
  task automatic test_random_traffic();
    int unsigned start;
    logic [CFG_DW-1:0] sc, wd, ch;
    logic lay;
    row_shape_e shape;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sc = 13'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0:       sc = 13'd0;
        1:       sc = 13'($urandom_range(4, 31));
        2:       sc = {8'($urandom), 5'($urandom_range(1, 3))};
        default: ;
      endcase
      wd  = 13'($urandom_range(0, 6));
      ch  = 13'($urandom_range(0, 3));
      lay = 1'($urandom_range(0, 1));
      // large factors only on one-element rows
      if (sc[4:0] > 3) begin
        wd = 13'($urandom_range(0, 1));
        ch = 13'($urandom_range(0, 1));
      end
      set_regs(sc, wd, ch, lay);
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IW'($urandom_range(4, 15)), 13'($urandom));
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) hold_req = $urandom_range(20, 60);
      repeat ($urandom_range(2, 5)) begin
        shape = ROW_CLEAN;
        if ($urandom_range(0, 3) == 0)
          shape = row_shape_e'($urandom_range(ROW_EARLY_PULL, ROW_EXTRA_PULL));
        play_row(shape);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_LOAD;
    cfg_valid = 1'b0;
    cfg_index = CFG_SCALE;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults_after_reset();
    test_scale_limits();
    test_zero_sizes();
    test_register_writes();
    test_full_rows();
    test_row_overflow();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
